### rtl/les_pkg.sv
package les_pkg;

	// table geometry
	localparam int MAX_EVENTS = 1024;
	localparam int IDX_W      = $clog2(MAX_EVENTS);
	localparam int NUM_W      = $clog2(MAX_EVENTS + 1);

	// field widths
	localparam int RATE_W  = 32;
	localparam int FRAC_W  = 32;
	localparam int HALF_W  = FRAC_W / 2;
	localparam int TOTAL_W = 42;
	localparam int CNT_W   = 11;
	localparam int EIDX_W  = 10;
	localparam int PSUM_W  = IDX_W + RATE_W;
	localparam int ALU_W   = TOTAL_W + HALF_W;

	// configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [0:0] REG_EVENT_COUNT = 1'b0;
	localparam logic [CNT_W-1:0] EVENT_COUNT_RST = CNT_W'(1024);

	// request types
	localparam logic REQ_UPDATE = 1'b0;
	localparam logic REQ_SELECT = 1'b1;

	// result status codes
	localparam logic [1:0] STAT_UPDATED   = 2'd0;
	localparam logic [1:0] STAT_CHOSEN    = 2'd1;
	localparam logic [1:0] STAT_NO_ACTIVE = 2'd2;
	localparam logic [1:0] STAT_BAD_INDEX = 2'd3;

	// shared unit operations
	localparam logic [1:0] ALU_ADD = 2'd0;
	localparam logic [1:0] ALU_SUB = 2'd1;
	localparam logic [1:0] ALU_MUL = 2'd2;

	typedef struct packed {
		logic [1:0]       op;
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
	} alu_req_t;

endpackage

### rtl/les_ram.sv
module les_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/les_alu.sv
module les_alu
	import les_pkg::*;
(
	input  alu_req_t         req,
	output logic [ALU_W-1:0] res
);

	// one adder/subtractor and one narrow multiplier, selected by op
	always_comb begin
		case (req.op)
			ALU_ADD: res = req.a + req.b;
			ALU_SUB: res = req.a - req.b;
			ALU_MUL: res = ALU_W'(req.a[TOTAL_W-1:0] * req.b[HALF_W-1:0]);
			default: res = '0;
		endcase
	end

endmodule

### rtl/linear_event_selector_unit.sv
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_ready   | req_type, entry_index, new_rate, random_fraction
// out     | output    | out_valid/out_ready | status, event_index, total_rate, active_count
// apb     | input     | psel/penable/pready | paddr, pwrite, pwdata, prdata (event_count)
//
// update: subtract the old rate from the total, add the new rate, write it back;
// select: scale the total by random_fraction, then walk the partial sums, one table
// entry per cycle through the shared adder; with no active entries, straight to result
// after reset all MAX_EVENTS rate table entries are cleared before in_ready rises
// one transaction is in work at a time; a finished result waits in the output register
// and a new transaction may be accepted meanwhile
module linear_event_selector_unit
	import les_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// input channel
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                req_type,
	input  logic [EIDX_W-1:0]   entry_index,
	input  logic [RATE_W-1:0]   new_rate,
	input  logic [FRAC_W-1:0]   random_fraction,
	// output channel
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          status,
	output logic [CNT_W-1:0]    event_index,
	output logic [TOTAL_W-1:0]  total_rate,
	output logic [CNT_W-1:0]    active_count,
	// configuration port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0]  prdata,
	output logic                pready
);

	localparam logic [3:0] ST_CLEAR   = 4'd0;
	localparam logic [3:0] ST_IDLE    = 4'd1;
	localparam logic [3:0] ST_UPD_SUB = 4'd2;
	localparam logic [3:0] ST_UPD_ADD = 4'd3;
	localparam logic [3:0] ST_MUL_HI  = 4'd4;
	localparam logic [3:0] ST_MUL_LO  = 4'd5;
	localparam logic [3:0] ST_SUM     = 4'd6;
	localparam logic [3:0] ST_WALK    = 4'd7;
	localparam logic [3:0] ST_RESULT  = 4'd8;

	logic [3:0]         state_q;
	logic [IDX_W-1:0]   clr_q;
	logic [CNT_W-1:0]   event_count_q;
	logic [TOTAL_W-1:0] total_q;
	logic [CNT_W-1:0]   count_q;

	logic [IDX_W-1:0]   idx_q;
	logic [RATE_W-1:0]  rate_q;
	logic [FRAC_W-1:0]  frac_q;
	logic               old_nz_q;
	logic [ALU_W-1:0]   hi_q;
	logic [ALU_W-1:0]   lo_q;
	logic [TOTAL_W-1:0] target_q;
	logic [PSUM_W-1:0]  partial_q;
	logic [NUM_W-1:0]   iss_q;
	logic [NUM_W-1:0]   chk_q;
	logic               rv_q;
	logic [1:0]         res_status_q;
	logic [NUM_W-1:0]   res_ev_q;

	logic               out_valid_q;
	logic [1:0]         status_q;
	logic [CNT_W-1:0]   event_index_q;
	logic [TOTAL_W-1:0] total_rate_q;
	logic [CNT_W-1:0]   active_count_q;

	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	logic [RATE_W-1:0]  ram_wdata;
	logic [IDX_W-1:0]   ram_raddr;
	logic [RATE_W-1:0]  ram_rdata;

	alu_req_t           alu_req;
	logic [ALU_W-1:0]   alu_res;

	logic               in_acc;
	logic               idx_bad;
	logic [NUM_W-1:0]   n_eff;
	logic [NUM_W-1:0]   chk_nxt;
	logic               cfg_wr;
	logic               out_free;

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign idx_bad  = (32'(entry_index) >= MAX_EVENTS);
	assign n_eff    = (32'(event_count_q) > MAX_EVENTS) ? NUM_W'(MAX_EVENTS)
	                                                    : NUM_W'(event_count_q);
	assign chk_nxt  = chk_q + NUM_W'(1);
	assign out_free = !out_valid_q || out_ready;

	// apb register access
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2:2] == REG_EVENT_COUNT);
	assign prdata = (paddr[2:2] == REG_EVENT_COUNT) ? PDATA_W'(event_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			event_count_q <= EVENT_COUNT_RST;
		end else if (cfg_wr) begin
			event_count_q <= pwdata[CNT_W-1:0];
		end
	end

	// rate table
	les_ram #(
		.WIDTH (RATE_W),
		.DEPTH (MAX_EVENTS)
	) u_rate_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = rate_q;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			ST_UPD_ADD: ram_we = 1'b1;
			default: ram_we = 1'b0;
		endcase
	end

	always_comb begin
		case (state_q)
			ST_IDLE: ram_raddr = IDX_W'(entry_index);
			ST_WALK: ram_raddr = iss_q[IDX_W-1:0];
			default: ram_raddr = idx_q;
		endcase
	end

	// operand selection for the shared unit
	always_comb begin
		alu_req = '{op: ALU_ADD, a: '0, b: '0};
		case (state_q)
			ST_UPD_SUB: alu_req = '{op: ALU_SUB, a: ALU_W'(total_q), b: ALU_W'(ram_rdata)};
			ST_UPD_ADD: alu_req = '{op: ALU_ADD, a: hi_q, b: ALU_W'(rate_q)};
			ST_MUL_HI:  alu_req = '{op: ALU_MUL, a: ALU_W'(total_q),
			                        b: ALU_W'(frac_q[FRAC_W-1:HALF_W])};
			ST_MUL_LO:  alu_req = '{op: ALU_MUL, a: ALU_W'(total_q),
			                        b: ALU_W'(frac_q[HALF_W-1:0])};
			ST_SUM:     alu_req = '{op: ALU_ADD, a: hi_q, b: lo_q >> HALF_W};
			ST_WALK:    alu_req = '{op: ALU_ADD, a: ALU_W'(partial_q), b: ALU_W'(ram_rdata)};
			default:    alu_req = '{op: ALU_ADD, a: '0, b: '0};
		endcase
	end

	les_alu u_alu (
		.req (alu_req),
		.res (alu_res)
	);

	// sequencer and table state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			total_q      <= '0;
			count_q      <= '0;
			rv_q         <= 1'b0;
			res_status_q <= STAT_UPDATED;
			res_ev_q     <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + IDX_W'(1);
					if (32'(clr_q) == MAX_EVENTS - 1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						res_ev_q <= '0;
						if (req_type == REQ_UPDATE) begin
							if (idx_bad) begin
								res_status_q <= STAT_BAD_INDEX;
								state_q      <= ST_RESULT;
							end else begin
								state_q <= ST_UPD_SUB;
							end
						end else if (count_q == '0) begin
							total_q      <= '0;
							res_status_q <= STAT_NO_ACTIVE;
							state_q      <= ST_RESULT;
						end else begin
							state_q <= ST_MUL_HI;
						end
					end
				end
				ST_UPD_SUB: state_q <= ST_UPD_ADD;
				ST_UPD_ADD: begin
					total_q      <= alu_res[TOTAL_W-1:0];
					count_q      <= count_q - CNT_W'(old_nz_q) + CNT_W'(rate_q != '0);
					res_status_q <= STAT_UPDATED;
					state_q      <= ST_RESULT;
				end
				ST_MUL_HI: state_q <= ST_MUL_LO;
				ST_MUL_LO: state_q <= ST_SUM;
				ST_SUM: begin
					rv_q         <= 1'b0;
					res_status_q <= STAT_CHOSEN;
					if (n_eff == '0) begin
						res_ev_q <= '0;
						state_q  <= ST_RESULT;
					end else begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					rv_q <= 1'b1;
					if (rv_q) begin
						if (alu_res > ALU_W'(target_q)) begin
							res_ev_q <= chk_q;
							state_q  <= ST_RESULT;
						end else if (chk_nxt == n_eff) begin
							res_ev_q <= n_eff;
							state_q  <= ST_RESULT;
						end
					end
				end
				ST_RESULT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				idx_q  <= IDX_W'(entry_index);
				rate_q <= new_rate;
				frac_q <= random_fraction;
			end
			ST_UPD_SUB: begin
				hi_q     <= alu_res;
				old_nz_q <= (ram_rdata != '0);
			end
			ST_MUL_HI: hi_q <= alu_res;
			ST_MUL_LO: lo_q <= alu_res;
			ST_SUM: begin
				target_q  <= alu_res[TOTAL_W+HALF_W-1:HALF_W];
				partial_q <= '0;
				iss_q     <= '0;
				chk_q     <= '0;
			end
			ST_WALK: begin
				iss_q <= iss_q + NUM_W'(1);
				if (rv_q) begin
					partial_q <= PSUM_W'(alu_res);
					chk_q     <= chk_nxt;
				end
			end
			default: begin
				idx_q <= idx_q;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_RESULT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESULT && out_free) begin
			status_q       <= res_status_q;
			event_index_q  <= CNT_W'(res_ev_q);
			total_rate_q   <= total_q;
			active_count_q <= count_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign event_index  = event_index_q;
	assign total_rate   = total_rate_q;
	assign active_count = active_count_q;

endmodule

### rtl/les_checker.sv
module les_checker
	import les_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [1:0]          status,
	input logic [CNT_W-1:0]    event_index,
	input logic [TOTAL_W-1:0]  total_rate,
	input logic [CNT_W-1:0]    active_count
);

	// a waiting result holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(event_index))
		else $error("result changed while stalled");

	// one transaction at a time: busy right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("accepted a transaction while busy");

	// no active events means an empty table and a cleared total
	a_no_active: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_NO_ACTIVE |-> total_rate == '0 && active_count == '0
		&& event_index == '0)
		else $error("no-active result with nonzero total or count");

	// only a chosen event carries an index
	a_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STAT_UPDATED || status == STAT_BAD_INDEX)
		|-> event_index == '0)
		else $error("index on a non-select result");

endmodule

bind linear_event_selector_unit les_checker u_les_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.status       (status),
	.event_index  (event_index),
	.total_rate   (total_rate),
	.active_count (active_count)
);
